[hw/rtl/vdt_pkg.sv]
// vdt_pkg: shared constants and types for the vertex dedup table.
// Used by vdt_regs, vdt_cell and vertex_dedup_table; no dependencies.
package vdt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int NUM_ATTR    = 8;
  localparam int ATTR_W      = 32;
  localparam int TOL_W       = 16;
  localparam int INDEX_W     = 10;
  localparam int NUM_CELLS   = 8;
  localparam int CELL_BITS   = $clog2(NUM_CELLS);
  localparam int ROWS        = TABLE_DEPTH / NUM_CELLS;
  localparam int ROW_BITS    = $clog2(ROWS);
  localparam int ENTRY_BITS  = ROW_BITS + CELL_BITS;
  localparam int COUNT_W     = ENTRY_BITS + 1;
  localparam int ROWS_W      = ROW_BITS + 1;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);
  localparam logic REG_TOL   = 1'b0;

  // attribute order: pos xyz, tex uv, normal xyz
  typedef logic [NUM_ATTR-1:0][ATTR_W-1:0] vdt_vtx_t;

  // row token that walks down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [ROW_BITS-1:0]  row;
    logic                 hit;
    logic [CELL_BITS-1:0] col;
  } vdt_tok_t;

  // append write, broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic [ROW_BITS-1:0]  row;
    logic [CELL_BITS-1:0] bank;
    vdt_vtx_t             data;
  } vdt_wr_t;

endpackage

[hw/rtl/vdt_regs.sv]
// vdt_regs: APB-style register port holding the match tolerance.
// Depends on vdt_pkg.
module vdt_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vdt_pkg::PADDR_W-1:0]   paddr,
  input  logic [vdt_pkg::PDATA_W-1:0]   pwdata,
  output logic [vdt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [vdt_pkg::TOL_W-1:0]     tol
);

  logic sel_tol;

  // word index is paddr[2]; byte offset bits are ignored
  assign sel_tol = (paddr[2] == vdt_pkg::REG_TOL);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= vdt_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && pready && sel_tol) begin
      tol <= pwdata[vdt_pkg::TOL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_tol) begin
      prdata = vdt_pkg::PDATA_W'(tol);
    end
  end

endmodule

[hw/rtl/vdt_cell.sv]
// vdt_cell: one bank of the vertex store plus its tolerance compare.
// A row token enters, the bank row is read, and the token leaves through the stage and tok_out registers.
// Depends on vdt_pkg.
module vdt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [vdt_pkg::CELL_BITS-1:0] cell_id,
  input  vdt_pkg::vdt_vtx_t             query,
  input  logic [vdt_pkg::TOL_W-1:0]     tol,
  input  logic [vdt_pkg::COUNT_W-1:0]   count,
  input  vdt_pkg::vdt_wr_t              wr,
  input  vdt_pkg::vdt_tok_t             tok_in,
  output vdt_pkg::vdt_tok_t             tok_out
);

  vdt_pkg::vdt_vtx_t mem [vdt_pkg::ROWS];
  vdt_pkg::vdt_vtx_t rd_data;
  vdt_pkg::vdt_tok_t stage;
  vdt_pkg::vdt_tok_t tok_pass;
  logic [vdt_pkg::NUM_ATTR-1:0] attr_ok;
  logic in_range;
  logic hit_here;

  // bank: one append write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en && (wr.bank == cell_id)) begin
      mem[wr.row] <= wr.data;
    end
    rd_data <= mem[tok_in.row];
  end

  // an earlier hit passes through untouched
  always_comb begin
    tok_pass = stage;
    if (hit_here) begin
      tok_pass.hit = 1'b1;
      tok_pass.col = cell_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage   <= '0;
      tok_out <= '0;
    end else begin
      stage   <= tok_in;
      tok_out <= tok_pass;
    end
  end

  // |stored - query| < tol, on exact 33-bit differences
  always_comb begin
    logic signed [vdt_pkg::ATTR_W:0] diff;
    logic signed [vdt_pkg::ATTR_W:0] tol_s;
    tol_s = $signed({{(vdt_pkg::ATTR_W + 1 - vdt_pkg::TOL_W){1'b0}}, tol});
    for (int a = 0; a < vdt_pkg::NUM_ATTR; a++) begin
      diff = $signed({rd_data[a][vdt_pkg::ATTR_W-1], rd_data[a]})
           - $signed({query[a][vdt_pkg::ATTR_W-1], query[a]});
      attr_ok[a] = (diff < tol_s) && (diff > -tol_s);
    end
  end

  assign in_range = ({1'b0, stage.row, cell_id} < count);
  assign hit_here = stage.valid && !stage.hit && in_range && (&attr_ok);

  property p_hit_in_range;
    @(posedge clk) disable iff (rst)
      hit_here |-> ({1'b0, stage.row, cell_id} < count);
  endproperty
  a_hit_in_range: assert property (p_hit_in_range)
    else $error("match reported on an unwritten entry");

  property p_hit_sticky;
    @(posedge clk) disable iff (rst)
      (stage.valid && stage.hit) |=> (tok_out.valid && tok_out.hit);
  endproperty
  a_hit_sticky: assert property (p_hit_sticky)
    else $error("earlier hit lost in the chain");

  property p_token_moves;
    @(posedge clk) disable iff (rst)
      tok_in.valid |=> ##1 (tok_out.valid && tok_out.row == $past(tok_in.row, 2));
  endproperty
  a_token_moves: assert property (p_token_moves)
    else $error("row token dropped or corrupted");

endmodule

[hw/rtl/vertex_dedup_table.sv]
// vertex_dedup_table: vertex welding table with per-attribute tolerance.
// A search issues ceil(entry_count/8) row tokens, one per cycle, into a chain of 8 cells
// (2 stages per cell); the result is loaded once the last token leaves; an empty table skips the scan.
// One request is in flight at a time; the next is taken the cycle after the result
// is loaded.
// Reset empties the table (entry count 0) and sets the tolerance to 66; no clearing pass.
module vertex_dedup_table (
  input  logic                        clk,
  input  logic                        rst,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vdt_pkg::PADDR_W-1:0] paddr,
  input  logic [vdt_pkg::PDATA_W-1:0] pwdata,
  output logic [vdt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic signed [31:0]          tex_u,
  input  logic signed [31:0]          tex_v,
  input  logic signed [31:0]          norm_x,
  input  logic signed [31:0]          norm_y,
  input  logic signed [31:0]          norm_z,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vdt_pkg::INDEX_W-1:0] vertex_index,
  output logic                        was_added,
  output logic                        table_full
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } vdt_state_t;

  vdt_state_t state;

  logic [vdt_pkg::TOL_W-1:0]      tol;
  vdt_pkg::vdt_vtx_t              query;
  logic [vdt_pkg::COUNT_W-1:0]    count;
  logic [vdt_pkg::ROWS_W-1:0]     rows_total;
  logic [vdt_pkg::ROWS_W-1:0]     issue_row;
  logic                           found;
  logic [vdt_pkg::ENTRY_BITS-1:0] hit_idx;
  vdt_pkg::vdt_wr_t               wr;
  vdt_pkg::vdt_tok_t              tok [vdt_pkg::NUM_CELLS+1];
  vdt_pkg::vdt_tok_t              tail;

  logic                           accept;
  logic                           commit;
  logic                           has_room;
  logic                           commit_add;
  logic [vdt_pkg::COUNT_W:0]      rows_sum;

  vdt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tol     (tol)
  );

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  // result register frees up this cycle or is already empty
  assign commit     = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign has_room   = (count < vdt_pkg::COUNT_W'(vdt_pkg::TABLE_DEPTH));
  assign commit_add = commit && !found && has_room;
  assign tail       = tok[vdt_pkg::NUM_CELLS];

  // rows holding at least one entry, rounded up
  assign rows_sum = {1'b0, count} + (vdt_pkg::COUNT_W + 1)'(vdt_pkg::NUM_CELLS - 1);

  // ---- sequencer ----
  // tok[0].valid is only raised while rows remain to issue and drops right
  // after the last one, so it is already low in every other state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      rows_total <= '0;
      issue_row  <= '0;
      found      <= 1'b0;
      tok[0]     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rows_total <= rows_sum[vdt_pkg::COUNT_W-1:vdt_pkg::CELL_BITS];
            issue_row  <= '0;
            found      <= 1'b0;
            state      <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (rows_total == '0) begin
            // empty table, nothing to scan
            state <= ST_FINISH;
          end else begin
            if (issue_row < rows_total) begin
              tok[0].valid <= 1'b1;
              tok[0].last  <= (issue_row == rows_total - 1'b1);
              tok[0].row   <= issue_row[vdt_pkg::ROW_BITS-1:0];
              tok[0].hit   <= 1'b0;
              tok[0].col   <= '0;
              issue_row    <= issue_row + 1'b1;
            end else begin
              tok[0].valid <= 1'b0;
            end
            // tokens leave in row order, so the first hit is the lowest index
            if (tail.valid && tail.hit && !found) begin
              found   <= 1'b1;
              hit_idx <= {tail.row, tail.col};
            end
            if (tail.valid && tail.last) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (commit) begin
            if (commit_add) begin
              count <= count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request payload held for the whole search
  always_ff @(posedge clk) begin
    if (accept) begin
      query <= {norm_z, norm_y, norm_x, tex_v, tex_u, pos_z, pos_y, pos_x};
    end
  end

  // append write, in the cycle after commit
  always_ff @(posedge clk) begin
    if (rst) begin
      wr.en <= 1'b0;
    end else begin
      wr.en <= commit_add;
    end
    if (commit_add) begin
      wr.row  <= count[vdt_pkg::ENTRY_BITS-1:vdt_pkg::CELL_BITS];
      wr.bank <= count[vdt_pkg::CELL_BITS-1:0];
      wr.data <= query;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (found) begin
        vertex_index <= vdt_pkg::INDEX_W'(hit_idx);
        was_added    <= 1'b0;
        table_full   <= 1'b0;
      end else if (has_room) begin
        vertex_index <= vdt_pkg::INDEX_W'(count);
        was_added    <= 1'b1;
        table_full   <= 1'b0;
      end else begin
        vertex_index <= '0;
        was_added    <= 1'b0;
        table_full   <= 1'b1;
      end
    end
  end

  // ---- cell chain ----
  for (genvar k = 0; k < vdt_pkg::NUM_CELLS; k++) begin : g_cell
    vdt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (vdt_pkg::CELL_BITS'(k)),
      .query   (query),
      .tol     (tol),
      .count   (count),
      .wr      (wr),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  // ---- checks ----
  property p_count_bound;
    @(posedge clk) disable iff (rst)
      count <= vdt_pkg::COUNT_W'(vdt_pkg::TABLE_DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("entry count beyond table depth");

  property p_flags_exclusive;
    @(posedge clk) disable iff (rst)
      out_valid |-> !(was_added && table_full);
  endproperty
  a_flags_exclusive: assert property (p_flags_exclusive)
    else $error("result both added and full");

  property p_tail_in_search;
    @(posedge clk) disable iff (rst)
      tail.valid |-> (state == ST_SEARCH);
  endproperty
  a_tail_in_search: assert property (p_tail_in_search)
    else $error("row token left the chain outside a search");

  property p_append_counts;
    @(posedge clk) disable iff (rst)
      commit_add |=> (count == $past(count) + 1'b1) && wr.en;
  endproperty
  a_append_counts: assert property (p_append_counts)
    else $error("append did not advance the entry count");

endmodule
